### rtl/swm_pkg.sv
// shared constants and types for the sliding window median core
package swm_pkg;

	localparam int unsigned WINDOW_MAX_DEF  = 64;
	localparam int unsigned SAMPLE_BITS_DEF = 32;
	localparam int unsigned CFG_BITS        = 7;
	localparam logic [CFG_BITS-1:0] WINDOW_RESET = 7'd3;
	localparam int unsigned GROUP_SIZE      = 8;

	typedef struct packed {
		logic upd;
		logic full;
	} win_ctl_t;

endpackage

### rtl/swm_cell.sv
// one entry of the sorted window: insert/shift selection and its storage
module swm_cell #(
	parameter int unsigned SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF,
	parameter int unsigned AGE_BITS    = 6
) (
	input  logic                          clk,
	input  logic                          upd,
	input  logic signed [SAMPLE_BITS-1:0] key,
	input  logic signed [SAMPLE_BITS-1:0] cur_val,
	input  logic        [AGE_BITS-1:0]    cur_age,
	input  logic                          cur_le,
	input  logic signed [SAMPLE_BITS-1:0] prv_val,
	input  logic        [AGE_BITS-1:0]    prv_age,
	input  logic                          prv_le,
	output logic signed [SAMPLE_BITS-1:0] nxt_val,
	output logic signed [SAMPLE_BITS-1:0] val_q,
	output logic        [AGE_BITS-1:0]    age_q
);

	logic [AGE_BITS-1:0] nxt_age;

	// below the insertion point keep, at it take the key, above it take the lower neighbour
	always_comb begin
		if (cur_le) begin
			nxt_val = cur_val;
			nxt_age = cur_age + 1'b1;
		end else if (prv_le) begin
			nxt_val = key;
			nxt_age = '0;
		end else begin
			nxt_val = prv_val;
			nxt_age = prv_age + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (upd) begin
			val_q <= nxt_val;
			age_q <= nxt_age;
		end
	end

endmodule

### rtl/swm_array.sv
// sorted window store: oldest entry removal, sorted insert and median group select
module swm_array #(
	parameter int unsigned WINDOW_MAX  = swm_pkg::WINDOW_MAX_DEF,
	parameter int unsigned SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF,
	localparam int unsigned CW = $clog2(WINDOW_MAX + 1),
	localparam int unsigned AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1,
	localparam int unsigned NG = (WINDOW_MAX + swm_pkg::GROUP_SIZE - 1) / swm_pkg::GROUP_SIZE
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  swm_pkg::win_ctl_t             ctl,
	input  logic signed [SAMPLE_BITS-1:0] key,
	input  logic        [CW-1:0]          fill,
	input  logic        [AW-1:0]          last_age,
	input  logic        [CW-1:0]          med_idx,
	output logic        [SAMPLE_BITS-1:0] grp [NG]
);

	localparam int unsigned G = swm_pkg::GROUP_SIZE;

	logic signed [SAMPLE_BITS-1:0] val_q   [WINDOW_MAX];
	logic        [AW-1:0]          age_q   [WINDOW_MAX];
	logic signed [SAMPLE_BITS-1:0] nxt_val [WINDOW_MAX];
	logic signed [SAMPLE_BITS-1:0] r_val   [WINDOW_MAX];
	logic        [AW-1:0]          r_age   [WINDOW_MAX];
	logic        [WINDOW_MAX-1:0]  le;
	logic        [WINDOW_MAX-1:0]  hit;
	logic        [AW-1:0]          old_idx;
	logic        [CW-1:0]          n_rem;

	// oldest entry carries the top age of a full window
	always_comb begin
		old_idx = '0;
		for (int j = 0; j < WINDOW_MAX; j++) begin
			hit[j] = ctl.full && (CW'(j) < fill) && (age_q[j] == last_age);
			if (hit[j])
				old_idx = old_idx | AW'(j);
		end
	end

	// window with the oldest entry squeezed out, and its compare flags
	always_comb begin
		n_rem = ctl.full ? fill - 1'b1 : fill;
		for (int j = 0; j < WINDOW_MAX; j++) begin
			if (j < WINDOW_MAX - 1 && ctl.full && AW'(j) >= old_idx) begin
				r_val[j] = val_q[(j + 1) % WINDOW_MAX];
				r_age[j] = age_q[(j + 1) % WINDOW_MAX];
			end else begin
				r_val[j] = val_q[j];
				r_age[j] = age_q[j];
			end
			le[j] = (CW'(j) < n_rem) && (r_val[j] <= key);
		end
	end

	for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
		if (i == 0) begin : g_first
			swm_cell #(
				.SAMPLE_BITS(SAMPLE_BITS),
				.AGE_BITS   (AW)
			) u_cell (
				.clk    (clk),
				.upd    (ctl.upd),
				.key    (key),
				.cur_val(r_val[i]),
				.cur_age(r_age[i]),
				.cur_le (le[i]),
				.prv_val(key),
				.prv_age('0),
				.prv_le (1'b1),
				.nxt_val(nxt_val[i]),
				.val_q  (val_q[i]),
				.age_q  (age_q[i])
			);
		end else begin : g_rest
			swm_cell #(
				.SAMPLE_BITS(SAMPLE_BITS),
				.AGE_BITS   (AW)
			) u_cell (
				.clk    (clk),
				.upd    (ctl.upd),
				.key    (key),
				.cur_val(r_val[i]),
				.cur_age(r_age[i]),
				.cur_le (le[i]),
				.prv_val(r_val[i-1]),
				.prv_age(r_age[i-1]),
				.prv_le (le[i-1]),
				.nxt_val(nxt_val[i]),
				.val_q  (val_q[i]),
				.age_q  (age_q[i])
			);
		end
	end

	// first level of the median select, one or-group per eight entries
	always_comb begin
		for (int g = 0; g < NG; g++) begin
			grp[g] = '0;
			for (int k = 0; k < G; k++) begin
				if (g * G + k < WINDOW_MAX) begin
					if (CW'(g * G + k) == med_idx)
						grp[g] = grp[g] | nxt_val[(g * G + k) % WINDOW_MAX];
				end
			end
		end
	end

	a_one_oldest: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.full |-> $onehot(hit))
		else $error("full window without a single oldest entry");

endmodule

### rtl/sliding_window_median_core.sv
// top level of the sliding window lower-median filter
//
//  channel       signals                                        dir   width
//  sample        sample_valid, sample_ready, sample             in    SAMPLE_BITS signed
//  median        median_valid, median_ready, median             out   SAMPLE_BITS signed
//  window_size   window_size_valid, window_size_ready, window_size  in  7 unsigned
//
//  one sample per cycle while sample_ready is high; the window store updates at the edge that takes the sample
//  a median leaves through the group select register, then the output register
//  a write to window_size empties the window; window_size_ready is always high
//  a stalled median output holds the result stage and then the sample input
//  reset clears fill count and handshake state and sets window_size to 3
module sliding_window_median_core #(
	parameter int unsigned WINDOW_MAX  = swm_pkg::WINDOW_MAX_DEF,
	parameter int unsigned SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  sample_valid,
	output logic                                  sample_ready,
	input  logic signed [SAMPLE_BITS-1:0]         sample,
	output logic                                  median_valid,
	input  logic                                  median_ready,
	output logic signed [SAMPLE_BITS-1:0]         median,
	input  logic                                  window_size_valid,
	output logic                                  window_size_ready,
	input  logic        [swm_pkg::CFG_BITS-1:0]   window_size
);

	localparam int unsigned CW = $clog2(WINDOW_MAX + 1);
	localparam int unsigned AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int unsigned NG = (WINDOW_MAX + swm_pkg::GROUP_SIZE - 1) / swm_pkg::GROUP_SIZE;
	localparam int unsigned EW = (swm_pkg::CFG_BITS > CW) ? swm_pkg::CFG_BITS : CW;

	logic [swm_pkg::CFG_BITS-1:0] win_size_q;
	logic [CW-1:0]                fill_q;
	logic [CW-1:0]                fill_nxt;
	logic [CW-1:0]                w_eff;
	logic [EW-1:0]                ws_ext;
	logic [CW-1:0]                w_less;
	logic [CW-1:0]                med_idx;
	logic [AW-1:0]                last_age;
	logic                         full;
	logic                         res_due;
	logic                         accept;
	logic                         cfg_wr;
	logic                         out_adv;
	logic                         s1_adv;
	logic                         res_valid_s1;
	logic [SAMPLE_BITS-1:0]       grp    [NG];
	logic [SAMPLE_BITS-1:0]       grp_s1 [NG];
	logic [SAMPLE_BITS-1:0]       median_c;
	logic signed [SAMPLE_BITS-1:0] median_q;
	logic                         median_valid_q;
	swm_pkg::win_ctl_t            ctl;

	// window size in use, held to 1..WINDOW_MAX
	always_comb begin
		ws_ext = EW'(win_size_q);
		if (ws_ext == '0)
			w_eff = CW'(1);
		else if (ws_ext > EW'(WINDOW_MAX))
			w_eff = CW'(WINDOW_MAX);
		else
			w_eff = CW'(ws_ext);
		w_less   = w_eff - 1'b1;
		last_age = AW'(w_less);
		med_idx  = w_less >> 1;
		full     = (fill_q == w_eff);
		fill_nxt = full ? fill_q : fill_q + 1'b1;
		res_due  = (fill_nxt == w_eff);
	end

	assign out_adv           = !median_valid_q || median_ready;
	assign s1_adv            = !res_valid_s1 || out_adv;
	assign sample_ready      = s1_adv;
	assign accept            = sample_valid && sample_ready;
	assign window_size_ready = 1'b1;
	assign cfg_wr            = window_size_valid && window_size_ready;
	assign ctl.upd           = accept;
	assign ctl.full          = full;

	swm_array #(
		.WINDOW_MAX (WINDOW_MAX),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_array (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.key     (sample),
		.fill    (fill_q),
		.last_age(last_age),
		.med_idx (med_idx),
		.grp     (grp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_size_q     <= swm_pkg::WINDOW_RESET;
			fill_q         <= '0;
			res_valid_s1   <= 1'b0;
			median_valid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				win_size_q <= window_size;
				fill_q     <= '0;
			end else if (accept) begin
				fill_q <= fill_nxt;
			end
			if (s1_adv)
				res_valid_s1 <= accept && res_due;
			if (out_adv)
				median_valid_q <= res_valid_s1;
		end
	end

	// second level of the median select
	always_comb begin
		median_c = '0;
		for (int g = 0; g < NG; g++)
			median_c = median_c | grp_s1[g];
	end

	always_ff @(posedge clk) begin
		if (accept && res_due)
			grp_s1 <= grp;
		if (out_adv && res_valid_s1)
			median_q <= median_c;
	end

	assign median       = median_q;
	assign median_valid = median_valid_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= w_eff)
		else $error("fill count beyond window size");

	a_cfg_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr |=> fill_q == '0)
		else $error("window not emptied by size write");

	a_free_takes: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid_s1 |-> sample_ready)
		else $error("sample refused with empty result stage");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		accept && res_due |=> res_valid_s1)
		else $error("median transaction lost");

endmodule

### tb/median_checker.sv
// checker for the sliding window median core: predicts medians and compares them
`timescale 1ns / 1ps

module median_checker #(
	parameter int unsigned WINDOW_MAX  = swm_pkg::WINDOW_MAX_DEF,
	parameter int unsigned SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic                                in_ready,
	input  logic signed [SAMPLE_BITS-1:0]       in_sample,
	input  logic                                out_valid,
	input  logic                                out_ready,
	input  logic signed [SAMPLE_BITS-1:0]       out_median,
	input  logic                                cfg_valid,
	input  logic                                cfg_ready,
	input  logic        [swm_pkg::CFG_BITS-1:0] cfg_data,
	output int unsigned                         outstanding,
	output int unsigned                         fail_count
);

	typedef logic signed [SAMPLE_BITS-1:0] smp_t;

	smp_t                        win_val [WINDOW_MAX];
	int unsigned                 win_age [WINDOW_MAX];
	int unsigned                 win_fill;
	logic [swm_pkg::CFG_BITS-1:0] win_cfg;
	smp_t                        expected_medians [$];
	int unsigned                 fails;

	task automatic note_failure(input string msg);
		fails++;
		if (fails <= 10)
			$display("[%0t] median mismatch: %s", $realtime, msg);
	endtask

	// oldest sample leaves, the rest age, new sample goes in at its sorted place
	task automatic insert_sample(input smp_t s);
		int unsigned w;
		int unsigned n;
		int unsigned oldest;
		int unsigned pos;
		int unsigned i;
		w = (win_cfg == 0) ? 1 : ((win_cfg > WINDOW_MAX) ? WINDOW_MAX : win_cfg);
		n = (win_fill > w) ? w : win_fill;
		if (n >= w) begin
			oldest = 0;
			for (i = 1; i < n; i++)
				if (win_age[i] > win_age[oldest])
					oldest = i;
			for (i = oldest; i + 1 < n; i++) begin
				win_val[i] = win_val[i + 1];
				win_age[i] = win_age[i + 1];
			end
			n--;
		end
		for (i = 0; i < n; i++)
			win_age[i]++;
		pos = 0;
		while (pos < n && win_val[pos] <= s)
			pos++;
		for (i = n; i > pos; i--) begin
			win_val[i] = win_val[i - 1];
			win_age[i] = win_age[i - 1];
		end
		win_val[pos] = s;
		win_age[pos] = 0;
		n++;
		win_fill = n;
		if (n == w)
			expected_medians = {expected_medians, win_val[(w - 1) / 2]};
	endtask

	always @(posedge clk or negedge arst_n) begin
		smp_t want;
		if (!arst_n) begin
			win_fill = 0;
			win_cfg = swm_pkg::WINDOW_RESET;
			expected_medians.delete();
			fails = 0;
			outstanding <= 0;
			fail_count <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				win_cfg = cfg_data;
				win_fill = 0;
			end
			if (in_valid && in_ready)
				insert_sample(in_sample);
			if (out_valid && out_ready) begin
				if (expected_medians.size() == 0) begin
					note_failure($sformatf("unexpected transaction, actual %0d", out_median));
				end else begin
					want = expected_medians.pop_front();
					if (out_median !== want)
						note_failure($sformatf("expected %0d, actual %0d", want, out_median));
				end
			end
			outstanding <= expected_medians.size();
			fail_count <= fails;
		end
	end

endmodule

### tb/tb_top.sv
// testbench top for the sliding window median core: stimulus, stalls and verdict
`timescale 1ns / 1ps

module tb_top;

	localparam int unsigned SB       = swm_pkg::SAMPLE_BITS_DEF;
	localparam int unsigned WMAX     = swm_pkg::WINDOW_MAX_DEF;
	localparam int unsigned WD_LIMIT = 2000;

	typedef logic signed [SB-1:0] smp_t;

	localparam smp_t SMP_MIN = {1'b1, {(SB-1){1'b0}}};
	localparam smp_t SMP_MAX = {1'b0, {(SB-1){1'b1}}};

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         sample_valid = 1'b0;
	logic                         sample_ready;
	smp_t                         sample = '0;
	logic                         median_valid;
	logic                         median_ready = 1'b1;
	smp_t                         median;
	logic                         window_size_valid = 1'b0;
	logic                         window_size_ready;
	logic [swm_pkg::CFG_BITS-1:0] window_size = '0;

	logic        idle_en = 1'b1;
	int unsigned ready_left = 0;
	int unsigned idle_cycles = 0;
	int unsigned items_sent = 0;
	int unsigned outstanding;
	int unsigned fail_count;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	sliding_window_median_core uut (
		.clk               (clk),
		.arst_n            (arst_n),
		.sample_valid      (sample_valid),
		.sample_ready      (sample_ready),
		.sample            (sample),
		.median_valid      (median_valid),
		.median_ready      (median_ready),
		.median            (median),
		.window_size_valid (window_size_valid),
		.window_size_ready (window_size_ready),
		.window_size       (window_size)
	);

	median_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (sample_valid),
		.in_ready    (sample_ready),
		.in_sample   (sample),
		.out_valid   (median_valid),
		.out_ready   (median_ready),
		.out_median  (median),
		.cfg_valid   (window_size_valid),
		.cfg_ready   (window_size_ready),
		.cfg_data    (window_size),
		.outstanding (outstanding),
		.fail_count  (fail_count)
	);

	// receiver stalls in bursts
	always @(posedge clk) begin
		if (!idle_en) begin
			median_ready <= 1'b1;
			ready_left <= 0;
		end else if (ready_left != 0) begin
			ready_left <= ready_left - 1;
		end else if (median_ready && $urandom_range(0, 3) == 0) begin
			median_ready <= 1'b0;
			ready_left <= $urandom_range(1, 18) - 1;
		end else begin
			median_ready <= 1'b1;
			ready_left <= $urandom_range(0, 20);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (sample_valid && sample_ready) || (median_valid && median_ready) ||
				(window_size_valid && window_size_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WD_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic smp_t pick_sample();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: return smp_t'($urandom);
			5, 6, 7:       return smp_t'(int'($urandom_range(0, 8)) - 4);
			8:             return $urandom_range(0, 1) ? SMP_MAX : SMP_MIN;
			default:       return $urandom_range(0, 1) ? SMP_MAX - smp_t'($urandom_range(0, 3))
			                                           : SMP_MIN + smp_t'($urandom_range(0, 3));
		endcase
	endfunction

	task automatic send_item(input smp_t v);
		int unsigned gap;
		if (idle_en && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 18);
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_valid <= 1'b1;
		sample <= v;
		@(posedge clk);
		while (!sample_ready) @(posedge clk);
		items_sent++;
	endtask

	task automatic drain();
		sample_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	// window size writes happen only with the core idle
	task automatic write_window(input logic [swm_pkg::CFG_BITS-1:0] v);
		drain();
		repeat (4) @(posedge clk);
		window_size_valid <= 1'b1;
		window_size <= v;
		@(posedge clk);
		while (!window_size_ready) @(posedge clk);
		window_size_valid <= 1'b0;
	endtask

	initial begin : stimulus
		smp_t                         seq [$];
		logic [swm_pkg::CFG_BITS-1:0] sz;
		int unsigned                  w;
		int unsigned                  count;
		int                           pause_at;
		int unsigned                  phase;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset window of three, extremes and repeated values
		seq = '{SMP_MIN, SMP_MAX, 0, -1, 1, SMP_MAX, SMP_MAX, SMP_MIN, SMP_MIN, 5, 5, 5,
			smp_t'(32'h5555_5555), smp_t'(32'haaaa_aaaa)};
		foreach (seq[k]) send_item(seq[k]);
		write_window(7'd2);
		seq = '{7, -7, 3, 3};
		foreach (seq[k]) send_item(seq[k]);
		write_window(7'd1);
		seq = '{SMP_MAX, SMP_MIN};
		foreach (seq[k]) send_item(seq[k]);
		write_window(7'd0);
		seq = '{9, -9};
		foreach (seq[k]) send_item(seq[k]);

		phase = 0;
		while (items_sent < 510) begin
			if (phase == 0)
				sz = 7'd127;
			else if (phase == 1)
				sz = 7'd64;
			else if ($urandom_range(0, 7) == 0)
				sz = 7'($urandom_range(0, 127));
			else
				sz = 7'($urandom_range(1, 12));
			w = (sz == 0) ? 1 : ((sz > WMAX) ? WMAX : sz);
			idle_en <= ($urandom_range(0, 3) != 0);
			write_window(sz);
			if (w > 1 && $urandom_range(0, 7) == 0)
				count = $urandom_range(0, w - 1);
			else
				count = w + $urandom_range(0, 30);
			pause_at = (phase == 2 || $urandom_range(0, 3) == 0) ? int'(count / 2) : -1;
			for (int k = 0; k < count; k++) begin
				if (k == pause_at)
					drain();
				send_item(pick_sample());
			end
			phase++;
		end

		// closing stretch without idling
		idle_en <= 1'b0;
		write_window(7'd5);
		repeat (40) send_item(pick_sample());
		drain();
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
